// ===== rtl/core/chgs_pkg.sv =====
// ----------------------------------------------------------------------------
// chgs_pkg
// Shared types and defaults for the Graham scan convex hull core.
// ----------------------------------------------------------------------------
package chgs_pkg;

    localparam int MAX_POINTS_DEF  = 32;
    localparam int COORD_WIDTH_DEF = 16;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SWAP1,
        ST_SWAP2,
        ST_SRD,
        ST_SGET,
        ST_SCHK,
        ST_SOPS,
        ST_SMUL,
        ST_SEV,
        ST_SPLACE,
        ST_TSTART,
        ST_TGET,
        ST_TCHK,
        ST_TOPS,
        ST_TMUL,
        ST_TEV,
        ST_DECIDE,
        ST_EMPTY,
        ST_CGET1,
        ST_CGET2,
        ST_CINIT3,
        ST_CRD,
        ST_CGET,
        ST_CCHK,
        ST_CMUL,
        ST_CEV,
        ST_CPGET,
        ST_CPUSH,
        ST_ERD,
        ST_EOUT,
        ST_DONE
    } t_state;

    // point store write data source
    typedef enum logic [2:0] {
        W_IN,
        W_P0,
        W_ANC,
        W_TMP,
        W_B,
        W_C
    } t_wsrc;

    // stack write data source
    typedef enum logic [1:0] {
        SW_ANC,
        SW_A,
        SW_B,
        SW_C
    } t_swsrc;

    // operand a source
    typedef enum logic [1:0] {
        A_ANC,
        A_B,
        A_SQ,
        A_Q
    } t_asrc;

    // operand b source
    typedef enum logic [1:0] {
        B_Q,
        B_A,
        B_C,
        B_TMP
    } t_bsrc;

    // controller to datapath commands
    typedef struct packed {
        logic   pt_we;
        t_wsrc  pt_wsrc;
        logic   st_we;
        t_swsrc st_wsrc;
        logic   ld_a;
        t_asrc  a_src;
        logic   ld_b;
        t_bsrc  b_src;
        logic   ld_c;
        logic   ld_tmp;
        logic   load_pt;
        logic   first_pt;
        logic   emit_pt;
        logic   emit_empty;
        logic   emit_last;
        logic   ovf;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic new_lower;
        logic turn_zero;
        logic turn_ccw;
        logic precedes;
    } t_stat;

endpackage

// ===== rtl/core/convex_hull_graham_scan_core.sv =====
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_core
// Convex hull of a loaded point set by Graham scan, hull emitted top down.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  point in | start, busy              | i_point_x, i_point_y, i_last_point
//  hull out | o_result_strobe          | o_hull_x, o_hull_y, o_hull_valid,
//           |                          | o_overflow, o_last_result
//
//  a point is taken on each start; busy stays low until the last point
//  after the last point: anchor swap, insertion sort (n*n/2 compare steps
//  worst case), thinning, scan pushes and pops, emit of each hull point;
//  the single-read point store sets the pace
//  reset clears the point count, stack depth and overflow flag; no clearing pass
//  results come one per strobe and cannot be held off by the receiver
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_core import chgs_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_last_point,
    output logic                          o_result_strobe,
    output logic signed [COORD_WIDTH-1:0] o_hull_x,
    output logic signed [COORD_WIDTH-1:0] o_hull_y,
    output logic                          o_hull_valid,
    output logic                          o_overflow,
    output logic                          o_last_result
);

    localparam int IW = $clog2(MAX_POINTS);

    t_cmd          cmd;
    t_stat         stat;
    logic [IW-1:0] pt_waddr, pt_raddr, st_waddr, st_raddr;

    chgs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_point (i_last_point),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_pt_waddr   (pt_waddr),
        .o_pt_raddr   (pt_raddr),
        .o_st_waddr   (st_waddr),
        .o_st_raddr   (st_raddr),
        .busy         (busy)
    );

    chgs_dp #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_cmd           (cmd),
        .i_pt_waddr      (pt_waddr),
        .i_pt_raddr      (pt_raddr),
        .i_st_waddr      (st_waddr),
        .i_st_raddr      (st_raddr),
        .o_stat          (stat),
        .o_hull_x        (o_hull_x),
        .o_hull_y        (o_hull_y),
        .o_hull_valid    (o_hull_valid),
        .o_overflow      (o_overflow),
        .o_last_result   (o_last_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

// ===== rtl/core/chgs_ram.sv =====
// ----------------------------------------------------------------------------
// chgs_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/core/chgs_dp.sv =====
// ----------------------------------------------------------------------------
// chgs_dp
// Datapath: point store, hull stack, operand registers, turn unit, outputs.
// ----------------------------------------------------------------------------
module chgs_dp import chgs_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  t_cmd                          i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_pt_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_pt_raddr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_st_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_st_raddr,
    output t_stat                         o_stat,
    output logic signed [COORD_WIDTH-1:0] o_hull_x,
    output logic signed [COORD_WIDTH-1:0] o_hull_y,
    output logic                          o_hull_valid,
    output logic                          o_overflow,
    output logic                          o_last_result,
    output logic                          o_result_strobe
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int SW = 2 * CW + 3;

    logic [2*CW-1:0] pt_wdata, pt_q, st_wdata, st_q;
    logic [2*CW-1:0] in_pt;

    logic [2*CW-1:0] r_p0, r_anc, r_tmp, r_a, r_b, r_c;

    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, anc_x, anc_y;
    logic signed [DW-1:0] d1, d2, d3, d4, e1, e2;
    logic signed [PW-1:0] r_p1, r_p2, r_q1, r_q2, r_q3, r_q4;
    logic signed [SW-1:0] v, dist_b, dist_c;
    logic                 za, zb;
    logic                 prec_ab;

    logic signed [CW-1:0] r_ox, r_oy;
    logic                 r_ovalid, r_oovf, r_olast, r_ostb;

    assign in_pt = {i_point_x, i_point_y};

    // point store write mux
    always_comb begin
        case (i_cmd.pt_wsrc)
            W_IN:    pt_wdata = in_pt;
            W_P0:    pt_wdata = r_p0;
            W_ANC:   pt_wdata = r_anc;
            W_TMP:   pt_wdata = r_tmp;
            W_B:     pt_wdata = r_b;
            W_C:     pt_wdata = r_c;
            default: pt_wdata = in_pt;
        endcase
    end

    // stack write mux
    always_comb begin
        case (i_cmd.st_wsrc)
            SW_ANC:  st_wdata = r_anc;
            SW_A:    st_wdata = r_a;
            SW_B:    st_wdata = r_b;
            SW_C:    st_wdata = r_c;
            default: st_wdata = r_c;
        endcase
    end

    chgs_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pt_we),
        .i_waddr (i_pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (i_pt_raddr),
        .o_rdata (pt_q)
    );

    chgs_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.st_we),
        .i_waddr (i_st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (i_st_raddr),
        .o_rdata (st_q)
    );

    assign anc_x = r_anc[2*CW-1:CW];
    assign anc_y = r_anc[CW-1:0];

    // anchor candidate test: lower y, then lower x
    assign o_stat.new_lower = (i_point_y < anc_y) || ((i_point_y == anc_y) && (i_point_x < anc_x));

    // operand and anchor registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            if (i_cmd.first_pt) begin
                r_p0 <= in_pt;
            end
            if (i_cmd.first_pt || o_stat.new_lower) begin
                r_anc <= in_pt;
            end
        end
        if (i_cmd.ld_tmp) begin
            r_tmp <= pt_q;
        end
        if (i_cmd.ld_a) begin
            case (i_cmd.a_src)
                A_ANC:   r_a <= r_anc;
                A_B:     r_a <= r_b;
                A_SQ:    r_a <= st_q;
                A_Q:     r_a <= pt_q;
                default: r_a <= r_anc;
            endcase
        end
        if (i_cmd.ld_b) begin
            case (i_cmd.b_src)
                B_Q:     r_b <= pt_q;
                B_A:     r_b <= r_a;
                B_C:     r_b <= r_c;
                B_TMP:   r_b <= r_tmp;
                default: r_b <= pt_q;
            endcase
        end
        if (i_cmd.ld_c) begin
            r_c <= pt_q;
        end
    end

    assign ax = r_a[2*CW-1:CW];
    assign ay = r_a[CW-1:0];
    assign bx = r_b[2*CW-1:CW];
    assign by = r_b[CW-1:0];
    assign cx = r_c[2*CW-1:CW];
    assign cy = r_c[CW-1:0];

    // differences for turn and distances
    assign d1 = DW'(by) - DW'(ay);
    assign d2 = DW'(cx) - DW'(bx);
    assign d3 = DW'(bx) - DW'(ax);
    assign d4 = DW'(cy) - DW'(by);
    assign e1 = DW'(cx) - DW'(ax);
    assign e2 = DW'(cy) - DW'(ay);

    // product stage
    always_ff @(posedge i_clk) begin
        r_p1 <= PW'(d1) * PW'(d2);
        r_p2 <= PW'(d3) * PW'(d4);
        r_q1 <= PW'(d3) * PW'(d3);
        r_q2 <= PW'(d1) * PW'(d1);
        r_q3 <= PW'(e1) * PW'(e1);
        r_q4 <= PW'(e2) * PW'(e2);
    end

    // turn sign and precedence
    assign v      = SW'(r_p1) - SW'(r_p2);
    assign dist_b = SW'(r_q1) + SW'(r_q2);
    assign dist_c = SW'(r_q3) + SW'(r_q4);
    assign za     = (r_b == r_a);
    assign zb     = (r_c == r_a);

    assign o_stat.turn_zero = (v == '0);
    assign o_stat.turn_ccw  = v[SW-1];
    assign o_stat.precedes  = prec_ab;

    always_comb begin
        if (za) begin
            prec_ab = !zb;
        end else if (zb) begin
            prec_ab = 1'b0;
        end else if (v[SW-1]) begin
            prec_ab = 1'b1;
        end else if (v == '0) begin
            prec_ab = (dist_b < dist_c);
        end else begin
            prec_ab = 1'b0;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ostb <= 1'b0;
        end else begin
            r_ostb <= i_cmd.emit_pt || i_cmd.emit_empty;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pt) begin
            r_ox     <= st_q[2*CW-1:CW];
            r_oy     <= st_q[CW-1:0];
            r_ovalid <= 1'b1;
            r_oovf   <= i_cmd.ovf;
            r_olast  <= i_cmd.emit_last;
        end else if (i_cmd.emit_empty) begin
            r_ox     <= '0;
            r_oy     <= '0;
            r_ovalid <= 1'b0;
            r_oovf   <= i_cmd.ovf;
            r_olast  <= 1'b1;
        end
    end

    assign o_hull_x        = r_ox;
    assign o_hull_y        = r_oy;
    assign o_hull_valid    = r_ovalid;
    assign o_overflow      = r_oovf;
    assign o_last_result   = r_olast;
    assign o_result_strobe = r_ostb;

endmodule

// ===== rtl/core/chgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// chgs_ctrl
// Controller: load, anchor swap, insertion sort, thinning, scan and emit.
// ----------------------------------------------------------------------------
module chgs_ctrl import chgs_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          i_last_point,
    input  t_stat                         i_stat,
    output t_cmd                          o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_pt_waddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_pt_raddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_st_waddr,
    output logic [$clog2(MAX_POINTS)-1:0] o_st_raddr,
    output logic                          busy
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam logic [NW-1:0] MAXN = NW'(MAX_POINTS);
    localparam logic [NW-1:0] ONE  = NW'(1);
    localparam logic [NW-1:0] TWO  = NW'(2);
    localparam logic [NW-1:0] THR  = NW'(3);

    t_state        r_state, n_state;
    logic [NW-1:0] r_count, n_count, r_i, n_i, r_j, n_j;
    logic [NW-1:0] r_kept, n_kept, r_d, n_d;
    logic [NW-1:0] i_nx, j_pv, d_m1, d_m3;
    logic [IW-1:0] r_best, n_best;
    logic          r_ovf, n_ovf;

    assign i_nx = r_i + ONE;
    assign j_pv = r_j - ONE;
    assign d_m1 = r_d - ONE;
    assign d_m3 = r_d - THR;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_kept  <= '0;
            r_d     <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_kept  <= n_kept;
            r_d     <= n_d;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_i        = r_i;
        n_j        = r_j;
        n_kept     = r_kept;
        n_d        = r_d;
        n_best     = r_best;
        n_ovf      = r_ovf;
        o_cmd      = '0;
        o_cmd.ovf  = r_ovf;
        o_pt_waddr = '0;
        o_pt_raddr = '0;
        o_st_waddr = '0;
        o_st_raddr = '0;
        busy       = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (r_count < MAXN) begin
                        o_cmd.pt_we    = 1'b1;
                        o_cmd.pt_wsrc  = W_IN;
                        o_pt_waddr     = r_count[IW-1:0];
                        o_cmd.load_pt  = 1'b1;
                        o_cmd.first_pt = (r_count == '0);
                        if ((r_count == '0) || i_stat.new_lower) begin
                            n_best = r_count[IW-1:0];
                        end
                        n_count = r_count + ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_point) begin
                        n_state = ST_SWAP1;
                    end
                end
            end
            // anchor to the front
            ST_SWAP1: begin
                o_cmd.pt_we   = 1'b1;
                o_cmd.pt_wsrc = W_P0;
                o_pt_waddr    = r_best;
                n_state       = ST_SWAP2;
            end
            ST_SWAP2: begin
                o_cmd.pt_we   = 1'b1;
                o_cmd.pt_wsrc = W_ANC;
                o_pt_waddr    = '0;
                n_i           = TWO;
                n_state       = (r_count >= THR) ? ST_SRD : ST_TSTART;
            end
            // insertion sort around the anchor
            ST_SRD: begin
                o_pt_raddr = r_i[IW-1:0];
                n_state    = ST_SGET;
            end
            ST_SGET: begin
                o_cmd.ld_tmp = 1'b1;
                n_j          = r_i;
                n_state      = ST_SCHK;
            end
            ST_SCHK: begin
                if (r_j > ONE) begin
                    o_pt_raddr = j_pv[IW-1:0];
                    n_state    = ST_SOPS;
                end else begin
                    n_state = ST_SPLACE;
                end
            end
            ST_SOPS: begin
                o_cmd.ld_a  = 1'b1;
                o_cmd.a_src = A_ANC;
                o_cmd.ld_b  = 1'b1;
                o_cmd.b_src = B_TMP;
                o_cmd.ld_c  = 1'b1;
                n_state     = ST_SMUL;
            end
            ST_SMUL: begin
                n_state = ST_SEV;
            end
            ST_SEV: begin
                if (i_stat.precedes) begin
                    o_cmd.pt_we   = 1'b1;
                    o_cmd.pt_wsrc = W_C;
                    o_pt_waddr    = r_j[IW-1:0];
                    n_j           = j_pv;
                    n_state       = ST_SCHK;
                end else begin
                    n_state = ST_SPLACE;
                end
            end
            ST_SPLACE: begin
                o_cmd.pt_we   = 1'b1;
                o_cmd.pt_wsrc = W_TMP;
                o_pt_waddr    = r_j[IW-1:0];
                n_i           = i_nx;
                n_state       = (i_nx < r_count) ? ST_SRD : ST_TSTART;
            end
            // keep farthest of each colinear run
            ST_TSTART: begin
                n_kept = ONE;
                if (r_count >= TWO) begin
                    o_pt_raddr = IW'(1);
                    n_state    = ST_TGET;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_TGET: begin
                o_cmd.ld_b  = 1'b1;
                o_cmd.b_src = B_Q;
                n_i         = ONE;
                n_state     = ST_TCHK;
            end
            ST_TCHK: begin
                if (i_nx < r_count) begin
                    o_pt_raddr = i_nx[IW-1:0];
                    n_state    = ST_TOPS;
                end else begin
                    o_cmd.pt_we   = 1'b1;
                    o_cmd.pt_wsrc = W_B;
                    o_pt_waddr    = r_kept[IW-1:0];
                    n_kept        = r_kept + ONE;
                    n_state       = ST_DECIDE;
                end
            end
            ST_TOPS: begin
                o_cmd.ld_a  = 1'b1;
                o_cmd.a_src = A_ANC;
                o_cmd.ld_c  = 1'b1;
                n_state     = ST_TMUL;
            end
            ST_TMUL: begin
                n_state = ST_TEV;
            end
            ST_TEV: begin
                if (!i_stat.turn_zero) begin
                    o_cmd.pt_we   = 1'b1;
                    o_cmd.pt_wsrc = W_B;
                    o_pt_waddr    = r_kept[IW-1:0];
                    n_kept        = r_kept + ONE;
                end
                o_cmd.ld_b  = 1'b1;
                o_cmd.b_src = B_C;
                n_i         = i_nx;
                n_state     = ST_TCHK;
            end
            ST_DECIDE: begin
                if (r_kept < THR) begin
                    n_state = ST_EMPTY;
                end else begin
                    o_pt_raddr = IW'(1);
                    n_state    = ST_CGET1;
                end
            end
            ST_EMPTY: begin
                o_cmd.emit_empty = 1'b1;
                n_state          = ST_DONE;
            end
            // stack seed: anchor and the first two sorted points
            ST_CGET1: begin
                o_cmd.ld_a    = 1'b1;
                o_cmd.a_src   = A_Q;
                o_cmd.st_we   = 1'b1;
                o_cmd.st_wsrc = SW_ANC;
                o_st_waddr    = '0;
                o_pt_raddr    = IW'(2);
                n_state       = ST_CGET2;
            end
            ST_CGET2: begin
                o_cmd.ld_b    = 1'b1;
                o_cmd.b_src   = B_Q;
                o_cmd.st_we   = 1'b1;
                o_cmd.st_wsrc = SW_A;
                o_st_waddr    = IW'(1);
                n_state       = ST_CINIT3;
            end
            ST_CINIT3: begin
                o_cmd.st_we   = 1'b1;
                o_cmd.st_wsrc = SW_B;
                o_st_waddr    = IW'(2);
                n_d           = THR;
                n_i           = THR;
                n_state       = (THR < r_kept) ? ST_CRD : ST_ERD;
            end
            // stack scan
            ST_CRD: begin
                o_pt_raddr = r_i[IW-1:0];
                n_state    = ST_CGET;
            end
            ST_CGET: begin
                o_cmd.ld_c = 1'b1;
                n_state    = ST_CCHK;
            end
            ST_CCHK: begin
                n_state = (r_d > TWO) ? ST_CMUL : ST_CPUSH;
            end
            ST_CMUL: begin
                n_state = ST_CEV;
            end
            ST_CEV: begin
                if (!i_stat.turn_ccw) begin
                    o_cmd.ld_b  = 1'b1;
                    o_cmd.b_src = B_A;
                    o_st_raddr  = d_m3[IW-1:0];
                    n_d         = d_m1;
                    n_state     = ST_CPGET;
                end else begin
                    n_state = ST_CPUSH;
                end
            end
            ST_CPGET: begin
                o_cmd.ld_a  = 1'b1;
                o_cmd.a_src = A_SQ;
                n_state     = ST_CCHK;
            end
            ST_CPUSH: begin
                o_cmd.st_we   = 1'b1;
                o_cmd.st_wsrc = SW_C;
                o_st_waddr    = r_d[IW-1:0];
                o_cmd.ld_a    = 1'b1;
                o_cmd.a_src   = A_B;
                o_cmd.ld_b    = 1'b1;
                o_cmd.b_src   = B_C;
                n_d           = r_d + ONE;
                n_i           = i_nx;
                n_state       = (i_nx < r_kept) ? ST_CRD : ST_ERD;
            end
            // emit from stack top down to the anchor
            ST_ERD: begin
                o_st_raddr = d_m1[IW-1:0];
                n_state    = ST_EOUT;
            end
            ST_EOUT: begin
                o_cmd.emit_pt   = 1'b1;
                o_cmd.emit_last = (r_d == ONE);
                n_d             = d_m1;
                n_state         = (r_d == ONE) ? ST_DONE : ST_ERD;
            end
            ST_DONE: begin
                n_count = '0;
                n_d     = '0;
                n_kept  = '0;
                n_ovf   = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/chgs_checker.sv =====
// ----------------------------------------------------------------------------
// chgs_checker
// Port-level checks for the convex hull core, bound to the top level.
// ----------------------------------------------------------------------------
module chgs_checker import chgs_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   i_last_point,
    input logic                   o_result_strobe,
    input logic [COORD_WIDTH-1:0] o_hull_x,
    input logic [COORD_WIDTH-1:0] o_hull_y,
    input logic                   o_hull_valid,
    input logic                   o_last_result
);

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without hull run");

    // empty hull is a single final result with zero coordinates
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_hull_valid) |-> (o_last_result && o_hull_x == '0
            && o_hull_y == '0))
        else $error("empty result malformed");

    // closing point starts a hull run
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_point) |=> busy)
        else $error("no hull run after last point");

    // nothing follows the final result
    a_final_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last_result) |=> !o_result_strobe)
        else $error("result after final result");

endmodule

bind convex_hull_graham_scan_core chgs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chgs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_last_point    (i_last_point),
    .o_result_strobe (o_result_strobe),
    .o_hull_x        (o_hull_x),
    .o_hull_y        (o_hull_y),
    .o_hull_valid    (o_hull_valid),
    .o_last_result   (o_last_result)
);

// ===== verif/convex_hull_graham_scan_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_core_tb
// Loads point sets one transfer at a time and checks each emitted hull point
// against a behavioral Graham scan kept in the bench. Directed sets cover the
// degenerate hulls, coordinate extremes, duplicate anchors and store overflow.
// Random sets follow, sent in bursts with random gaps between transfers.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_core_tb import chgs_pkg::*; ();

    localparam int    NPTS      = MAX_POINTS_DEF;
    localparam int    CW        = COORD_WIDTH_DEF;
    localparam int    N_RANDOM  = 320;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 valid;
        logic                 ovf;
        logic                 last;
    } hull_pt_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } pt_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
        logic                 chk;   // typed-in hull expected for this row
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic                 ev;
    } row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] i_point_x;
    logic signed [CW-1:0] i_point_y;
    logic                 i_last_point;
    logic                 o_result_strobe;
    logic signed [CW-1:0] o_hull_x;
    logic signed [CW-1:0] o_hull_y;
    logic                 o_hull_valid;
    logic                 o_overflow;
    logic                 o_last_result;

    // hull model state
    pt_t      set_pts[NPTS];
    int       set_count;
    logic     set_ovf;
    hull_pt_t hull_q[$];

    int     fail_cnt;
    int     hull_pts_seen;
    int     sets_done;
    longint cycle_cnt;

    convex_hull_graham_scan_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_last_point    (i_last_point),
        .o_result_strobe (o_result_strobe),
        .o_hull_x        (o_hull_x),
        .o_hull_y        (o_hull_y),
        .o_hull_valid    (o_hull_valid),
        .o_overflow      (o_overflow),
        .o_last_result   (o_last_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cross product sign: 0 colinear, 1 clockwise, 2 counterclockwise
    function automatic int orient(pt_t a, pt_t b, pt_t c);
        longint v;
        v = (longint'(b.y) - a.y) * (longint'(c.x) - b.x)
          - (longint'(b.x) - a.x) * (longint'(c.y) - b.y);
        if (v == 0) return 0;
        return (v < 0) ? 2 : 1;
    endfunction

    function automatic longint sq_dist(pt_t a, pt_t b);
        longint dx, dy;
        dx = longint'(a.x) - b.x;
        dy = longint'(a.y) - b.y;
        return dx * dx + dy * dy;
    endfunction

    function automatic bit sorts_first(pt_t o, pt_t a, pt_t b);
        bit za, zb;
        int t;
        za = (a.x == o.x) && (a.y == o.y);
        zb = (b.x == o.x) && (b.y == o.y);
        if (za) return !zb;
        if (zb) return 1'b0;
        t = orient(o, a, b);
        if (t == 2) return 1'b1;
        if (t == 1) return 1'b0;
        return sq_dist(o, a) < sq_dist(o, b);
    endfunction

    // store one point; on the closing point compute the hull into hull_q
    task automatic add_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic last);
        int     n, best, kept, depth, j;
        pt_t    tmp, anc;
        int     stk[NPTS];
        hull_pt_t h;
        if (set_count < NPTS) begin
            set_pts[set_count].x = x;
            set_pts[set_count].y = y;
            set_count++;
        end else begin
            set_ovf = 1'b1;
        end
        if (!last) return;
        n = set_count;
        kept = 0;
        if (n > 0) begin
            best = 0;
            for (int i = 1; i < n; i++)
                if (set_pts[i].y < set_pts[best].y || (set_pts[i].y == set_pts[best].y
                        && set_pts[i].x < set_pts[best].x))
                    best = i;
            tmp = set_pts[0]; set_pts[0] = set_pts[best]; set_pts[best] = tmp;
            anc = set_pts[0];
            // insertion sort by angle around the anchor
            for (int i = 2; i < n; i++) begin
                tmp = set_pts[i];
                j = i;
                while (j > 1 && sorts_first(anc, tmp, set_pts[j-1])) begin
                    set_pts[j] = set_pts[j-1];
                    j--;
                end
                set_pts[j] = tmp;
            end
            // keep the farthest of each colinear run
            kept = 1;
            for (int i = 1; i < n; i++) begin
                while (i + 1 < n && orient(anc, set_pts[i], set_pts[i+1]) == 0) i++;
                set_pts[kept] = set_pts[i];
                kept++;
            end
        end
        if (kept < 3) begin
            h.x = '0; h.y = '0; h.valid = 1'b0; h.ovf = set_ovf; h.last = 1'b1;
            hull_q.insert(hull_q.size(), h);
        end else begin
            stk[0] = 0; stk[1] = 1; stk[2] = 2;
            depth = 3;
            for (int i = 3; i < kept; i++) begin
                while (depth > 2 && orient(set_pts[stk[depth-2]], set_pts[stk[depth-1]],
                        set_pts[i]) != 2)
                    depth--;
                if (depth < NPTS) begin
                    stk[depth] = i;
                    depth++;
                end
            end
            while (depth > 0) begin
                depth--;
                h.x = set_pts[stk[depth]].x;
                h.y = set_pts[stk[depth]].y;
                h.valid = 1'b1;
                h.ovf = set_ovf;
                h.last = (depth == 0);
                hull_q.insert(hull_q.size(), h);
            end
        end
        set_count = 0;
        set_ovf = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        hull_pt_t e;
        if (i_rst_n && o_result_strobe) begin
            hull_pts_seen++;
            if (hull_q.size() == 0) begin
                $display("%0t: unexpected hull result x=%0d y=%0d", $time, o_hull_x, o_hull_y);
                fail_cnt++;
            end else begin
                e = hull_q.pop_front();
                if (o_hull_x !== e.x || o_hull_y !== e.y || o_hull_valid !== e.valid
                        || o_overflow !== e.ovf || o_last_result !== e.last) begin
                    $display("%0t: hull mismatch exp x=%0d y=%0d v=%0b ovf=%0b last=%0b",
                             $time, e.x, e.y, e.valid, e.ovf, e.last);
                    $display("%0t:               got x=%0d y=%0d v=%0b ovf=%0b last=%0b",
                             $time, o_hull_x, o_hull_y, o_hull_valid, o_overflow,
                             o_last_result);
                    fail_cnt++;
                end
                if (e.last) sets_done++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one point transfer with the given idle gap ahead of it
    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic last, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_last_point <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        add_point(x, y, last);
    endtask

    // directed table: typed-in expectations only for trivial empty hulls
    row_t dir_rows[$];

    function automatic row_t mk(int x, int y, bit last, bit chk = 0);
        row_t r;
        r.x = CW'(x); r.y = CW'(y); r.last = last;
        r.chk = chk; r.ex = '0; r.ey = '0; r.ev = 1'b0;
        return r;
    endfunction

    // random point set, mostly well spread, sometimes tiny or colinear
    task automatic send_random_set(int npts, int burst_left);
        int mode, span, gap;
        logic signed [CW-1:0] x, y;
        mode = $urandom_range(0, 5);
        span = (mode == 0) ? 32767 : (mode == 1) ? 3 : $urandom_range(4, 2000);
        for (int i = 0; i < npts; i++) begin
            if (mode == 2) begin
                x = CW'(i * 3); y = CW'(i * 5);
            end else if (mode == 0) begin
                x = CW'($urandom); y = CW'($urandom);
            end else begin
                x = CW'(int'($urandom_range(0, 2 * span)) - span);
                y = CW'(int'($urandom_range(0, 2 * span)) - span);
            end
            if (burst_left > 0) begin
                gap = 0; burst_left--;
            end else begin
                gap = $urandom_range(1, 6); burst_left = $urandom_range(0, 12);
            end
            send_point(x, y, i == npts - 1, gap);
        end
    endtask

    initial begin
        int sent, npts;
        row_t r;
        fail_cnt = 0; hull_pts_seen = 0; sets_done = 0; cycle_cnt = 0;
        set_count = 0; set_ovf = 1'b0;
        i_rst_n = 1'b0; start = 1'b0;
        i_point_x = '0; i_point_y = '0; i_last_point = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single point and two points give an empty hull
        dir_rows.insert(dir_rows.size(), mk(5, 5, 1, 1));
        dir_rows.insert(dir_rows.size(), mk(-32768, 32767, 0));
        dir_rows.insert(dir_rows.size(), mk(32767, -32768, 1, 1));
        // all colinear collapses to two points
        dir_rows.insert(dir_rows.size(), mk(0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(10, 10, 0));
        dir_rows.insert(dir_rows.size(), mk(5, 5, 1, 1));
        // extreme square with a duplicated anchor and inner points
        dir_rows.insert(dir_rows.size(), mk(32767, 32767, 0));
        dir_rows.insert(dir_rows.size(), mk(-32768, -32768, 0));
        dir_rows.insert(dir_rows.size(), mk(32767, -32768, 0));
        dir_rows.insert(dir_rows.size(), mk(-32768, -32768, 0));
        dir_rows.insert(dir_rows.size(), mk(0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(-32768, 32767, 0));
        dir_rows.insert(dir_rows.size(), mk(-1, -1, 1));
        // quadrilateral with a colinear edge point and a pop
        dir_rows.insert(dir_rows.size(), mk(0, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(4, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(2, 0, 0));
        dir_rows.insert(dir_rows.size(), mk(2, 1, 0));
        dir_rows.insert(dir_rows.size(), mk(3, 3, 0));
        dir_rows.insert(dir_rows.size(), mk(0, 4, 1));
        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            send_point(r.x, r.y, r.last, $urandom_range(0, 2));
            if (r.chk && (hull_q.size() != 1 || hull_q[$].valid !== r.ev
                    || hull_q[$].x !== r.ex || hull_q[$].y !== r.ey)) begin
                $display("%0t: hull model disagrees with table row %0d", $time, k);
                fail_cnt++;
            end
        end

        // overflow: one more point than the store holds, closing on the drop
        for (int i = 0; i <= NPTS; i++)
            send_point(CW'($urandom), CW'($urandom), i == NPTS, 0);

        // random sets
        sent = 0;
        while (sent < N_RANDOM) begin
            npts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) :
                   ($urandom_range(0, 15) == 0) ? NPTS : $urandom_range(3, 14);
            send_random_set(npts, $urandom_range(0, 8));
            sent += npts;
        end
        start <= 1'b0;

        while (hull_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d point sets, %0d hull results checked", sets_done,
                 hull_pts_seen);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
